>>> rtl/multi_channel_tachometer_defines.svh
// Assertion macros shared by the tachometer RTL.
`ifndef MULTI_CHANNEL_TACHOMETER_DEFINES_SVH
`define MULTI_CHANNEL_TACHOMETER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mct_pkg.sv
package mct_pkg;

   // Defaults for the top-level parameters
   localparam int CHANNELS_DEF     = 15;
   localparam int COUNTER_BITS_DEF = 16;

   // Fixed field widths
   localparam int SCALE_W   = 24;
   localparam int TIMEOUT_W = 8;
   localparam int CHAN_W    = 4;
   localparam int MASK_W    = 15;
   localparam int STALL_W   = 8;

   // One quotient bit per divider step
   localparam int DIV_STEPS = SCALE_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Register reset values
   localparam logic [SCALE_W-1:0]   SCALE_RESET   = 24'd120000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd20;

   // Item function codes
   localparam logic FUNC_CAPTURE = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SPEED_SCALE = 1'b0;
   localparam logic REG_TIMEOUT     = 1'b1;

   typedef struct packed {
      logic [SCALE_W-1:0]   speed_scale;
      logic [TIMEOUT_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_WALK = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

endpackage

>>> rtl/mct_csr.sv
module mct_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mct_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mct_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mct_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output mct_pkg::cfg_type                 cfg
);

   mct_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic             reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   // Decode the write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            mct_pkg::REG_SPEED_SCALE: cfg_in.speed_scale   = pwdata[mct_pkg::SCALE_W-1:0];
            mct_pkg::REG_TIMEOUT:     cfg_in.timeout_ticks = pwdata[mct_pkg::TIMEOUT_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_scale   <= mct_pkg::SCALE_RESET;
         cfg_ff.timeout_ticks <= mct_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_sel)
         mct_pkg::REG_SPEED_SCALE:
            prdata = {{(mct_pkg::CSR_DATA_W-mct_pkg::SCALE_W){1'b0}}, cfg_ff.speed_scale};
         mct_pkg::REG_TIMEOUT:
            prdata = {{(mct_pkg::CSR_DATA_W-mct_pkg::TIMEOUT_W){1'b0}}, cfg_ff.timeout_ticks};
         default:
            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/mct_divider.sv
`include "multi_channel_tachometer_defines.svh"

module mct_divider #(
   parameter int COUNTER_BITS = mct_pkg::COUNTER_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mct_pkg::SCALE_W-1:0]   dividend,
   input  logic [COUNTER_BITS:0]         divisor,
   output mct_pkg::div_status_type       status,
   output logic [mct_pkg::SCALE_W-1:0]   quotient
);

   localparam int REM_W = COUNTER_BITS + 1;
   localparam logic [mct_pkg::STEP_W-1:0] LAST_STEP = mct_pkg::STEP_W'(mct_pkg::DIV_STEPS - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [mct_pkg::STEP_W-1:0]    count_ff, count_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [mct_pkg::SCALE_W-1:0]   quot_ff, quot_in;
   logic [COUNTER_BITS:0]         div_ff, div_in;
   logic [REM_W:0]                trial;
   logic [REM_W:0]                diff;
   logic                          q_bit;

   // Shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quot_ff[mct_pkg::SCALE_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign q_bit = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quot_in  = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = q_bit ? diff[REM_W-1:0] : trial[REM_W-1:0];
         quot_in  = {quot_ff[mct_pkg::SCALE_W-2:0], q_bit};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

   `MCT_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff, "divider did not start")
   `MCT_ASSERT_NEXT(a_last_done, clock, reset, busy_ff && !start && count_ff == LAST_STEP,
                    done_ff && !busy_ff, "divider missed its last step")

endmodule

>>> rtl/multi_channel_tachometer.sv
// Fifteen-channel input-capture tachometer. A capture beat (func 0) gives the period since
// the channel's previous capture, modulo 2^COUNTER_BITS with a zero difference taken as a
// full wrap, and returns speed = speed_scale / period, truncated; it also clears that
// channel's stall count. A tick beat (func 1) advances every stall count and returns the
// mask of channels that reached timeout_ticks, whose counts are cleared. Captures on a
// channel at or above CHANNELS return speed zero and change nothing. One item is worked
// at a time: req_ready is high only while the sequencer is idle. A capture runs the
// bit-serial restoring divider in S_DIV, then S_DONE loads its result; a tick walks
// one channel's stall count per cycle in S_WALK, then goes to S_DONE. An out-of-range
// capture goes from S_IDLE straight to S_DONE. The result sits in an output register, so
// a new item is taken while the previous result waits. No clearing pass follows reset.
`include "multi_channel_tachometer_defines.svh"

module multi_channel_tachometer #(
   parameter int CHANNELS     = mct_pkg::CHANNELS_DEF,
   parameter int COUNTER_BITS = mct_pkg::COUNTER_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // capture / tick beats
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  logic [mct_pkg::CHAN_W-1:0]       req_channel,
   input  logic [COUNTER_BITS-1:0]          req_capture_value,
   // results
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mct_pkg::CHAN_W-1:0]       rsp_out_channel,
   output logic [mct_pkg::SCALE_W-1:0]      rsp_speed,
   output logic [mct_pkg::MASK_W-1:0]       rsp_stopped_mask,
   // configuration
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mct_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mct_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mct_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W = ((IDX_W > mct_pkg::CHAN_W) ? IDX_W : mct_pkg::CHAN_W) + 1;
   localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(CHANNELS - 1);
   localparam logic [mct_pkg::STALL_W-1:0] STALL_MAX = '1;

   mct_pkg::cfg_type          cfg;
   mct_pkg::div_status_type   div_status;
   logic [mct_pkg::SCALE_W-1:0] quotient;

   mct_pkg::state_type        state_ff, state_in;
   logic [mct_pkg::CHAN_W-1:0]  chan_ff, chan_in;
   logic [mct_pkg::SCALE_W-1:0] speed_ff, speed_in;
   logic [mct_pkg::MASK_W-1:0]  mask_ff, mask_in;
   logic [IDX_W-1:0]            walk_ff, walk_in;

   logic [COUNTER_BITS-1:0]     last_cap_ff [CHANNELS];
   logic [COUNTER_BITS-1:0]     last_cap_in [CHANNELS];
   logic [mct_pkg::STALL_W-1:0] stall_ff    [CHANNELS];
   logic [mct_pkg::STALL_W-1:0] stall_in    [CHANNELS];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mct_pkg::CHAN_W-1:0]  rsp_chan_ff, rsp_chan_in;
   logic [mct_pkg::SCALE_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic [mct_pkg::MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;

   logic                        req_fire;
   logic [CMP_W-1:0]            chan_wide;
   logic                        chan_ok;
   logic [IDX_W-1:0]            cap_idx;
   logic [COUNTER_BITS-1:0]     cap_diff;
   logic [COUNTER_BITS:0]       period;
   logic                        div_start;
   logic [mct_pkg::STALL_W-1:0] stall_inc;
   logic                        expire;
   logic                        load_rsp;

   mct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mct_divider #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg.speed_scale),
      .divisor  (period),
      .status   (div_status),
      .quotient (quotient)
   );

   assign req_ready = (state_ff == mct_pkg::S_IDLE);
   assign req_fire  = req_valid & req_ready;

   // Capture path: range check, period with full wrap on equal values
   assign chan_wide = CMP_W'(req_channel);
   assign chan_ok   = (chan_wide < CMP_W'(CHANNELS));
   assign cap_idx   = chan_wide[IDX_W-1:0];
   assign cap_diff  = req_capture_value - last_cap_ff[cap_idx];
   assign period    = {(cap_diff == '0), cap_diff};
   assign div_start = req_fire && (req_func == mct_pkg::FUNC_CAPTURE) && chan_ok;

   // Tick walk: saturating increment and timeout compare for one channel
   assign stall_inc = (stall_ff[walk_ff] == STALL_MAX) ? STALL_MAX : stall_ff[walk_ff] + 1'b1;
   assign expire    = (stall_inc >= cfg.timeout_ticks);

   // A finished result waits in S_DONE and the result register is free this cycle
   assign load_rsp  = (state_ff == mct_pkg::S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      chan_in     = chan_ff;
      speed_in    = speed_ff;
      mask_in     = mask_ff;
      walk_in     = walk_ff;
      last_cap_in = last_cap_ff;
      stall_in    = stall_ff;
      case (state_ff)
         mct_pkg::S_IDLE: begin
            if (req_fire) begin
               speed_in = '0;
               mask_in  = '0;
               walk_in  = '0;
               if (req_func == mct_pkg::FUNC_TICK) begin
                  chan_in  = '0;
                  state_in = mct_pkg::S_WALK;
               end else begin
                  chan_in = req_channel;
                  if (chan_ok) begin
                     last_cap_in[cap_idx] = req_capture_value;
                     stall_in[cap_idx]    = '0;
                     state_in             = mct_pkg::S_DIV;
                  end else begin
                     state_in = mct_pkg::S_DONE;
                  end
               end
            end
         end
         mct_pkg::S_DIV: begin
            if (div_status.done) begin
               speed_in = quotient;
               state_in = mct_pkg::S_DONE;
            end
         end
         mct_pkg::S_WALK: begin
            if (expire) begin
               stall_in[walk_ff] = '0;
               if (int'(walk_ff) < mct_pkg::MASK_W) begin
                  mask_in = mask_ff | (mct_pkg::MASK_W'(1) << walk_ff);
               end
            end else begin
               stall_in[walk_ff] = stall_inc;
            end
            walk_in = walk_ff + 1'b1;
            if (walk_ff == LAST_CH) begin
               state_in = mct_pkg::S_DONE;
            end
         end
         mct_pkg::S_DONE: begin
            if (load_rsp) begin
               state_in = mct_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mct_pkg::S_IDLE;
         end
      endcase
   end

   // Output register: drop the beat once taken, load a finished result
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_mask_in  = rsp_mask_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_chan_in  = chan_ff;
         rsp_speed_in = speed_ff;
         rsp_mask_in  = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mct_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            last_cap_ff[c] <= '0;
            stall_ff[c]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_ff      <= walk_in;
         last_cap_ff  <= last_cap_in;
         stall_ff     <= stall_in;
      end
      chan_ff      <= chan_in;
      speed_ff     <= speed_in;
      mask_ff      <= mask_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = rsp_chan_ff;
   assign rsp_speed        = rsp_speed_ff;
   assign rsp_stopped_mask = rsp_mask_ff;

   `MCT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready,
                    "ready stayed high after a beat was taken")
   `MCT_ASSERT_NOW(a_div_running, clock, reset, state_ff == mct_pkg::S_DIV,
                   div_status.busy || div_status.done, "sequencer waits on an idle divider")
   `MCT_ASSERT_NOW(a_tick_result, clock, reset, rsp_valid_ff && rsp_mask_ff != '0,
                   rsp_speed_ff == '0 && rsp_chan_ff == '0, "tick result carries a speed")

endmodule
